// File: hw/rtl/prime_value_filter_macros.svh
// assertion macros shared by the prime value filter modules
`ifndef PRIME_VALUE_FILTER_MACROS_SVH
`define PRIME_VALUE_FILTER_MACROS_SVH

// expression must never hold outside reset
`define PVF_ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("prime value filter: forbidden condition seen");

// antecedent implies consequent in the same cycle
`define PVF_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prime value filter: implication failed");

// antecedent implies consequent in the next cycle
`define PVF_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prime value filter: next-cycle implication failed");

`endif

// File: hw/rtl/pvf_pkg.sv
// shared types and class codes of the prime value filter
package pvf_pkg;

  // class given to each word by the front part
  typedef logic [0:0] item_class_t;
  localparam item_class_t CLASS_PASS  = 1'b0;  // never prime, passes as is
  localparam item_class_t CLASS_TRIAL = 1'b1;  // needs trial division

  // head-of-queue status seen by the back part
  typedef struct packed {
    logic        valid;
    item_class_t cls;
  } queue_tag_t;

endpackage

// File: hw/rtl/prime_value_filter.sv
// top level of the prime value filter: drops prime words from a stream
//
//   channel   direction   handshake                 payload
//   value     in          value_valid/value_ready   value      (VALUE_BITS, signed)
//   kept      out         kept_valid/kept_ready     kept_value (VALUE_BITS, signed)
//
// negative words, zero and one pass through the front register, queue and result register
// other words go through trial division, divisors 2, 3, ... while d*d <= n
// each divisor passes check, one remainder step per magnitude bit and test in the single bit-serial remainder unit
// worst case for 16 bits is about 181 divisors per word
// front part keeps accepting while the queue has room; the result register decouples kept_ready
// synchronous reset empties the front register, queue and result register; no clearing pass
module prime_value_filter
  import pvf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         kept_valid,
  input  logic                         kept_ready,
  output logic signed [VALUE_BITS-1:0] kept_value
);

  // front to queue
  logic                  push;
  logic [VALUE_BITS-1:0] push_value;
  item_class_t           push_cls;
  logic                  queue_full;

  // queue to back
  queue_tag_t            head_tag;
  logic [VALUE_BITS-1:0] head_value;
  logic                  pop;

  // accepts each word and marks whether it needs trial division
  pvf_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .push        (push),
    .push_value  (push_value),
    .push_cls    (push_cls),
    .queue_full  (queue_full)
  );

  // two-entry queue lets the front run ahead of a long division
  pvf_queue #(
    .VALUE_BITS (VALUE_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .push_cls   (push_cls),
    .full       (queue_full),
    .pop        (pop),
    .head_tag   (head_tag),
    .head_value (head_value)
  );

  // trial division and the result register
  pvf_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_tag   (head_tag),
    .head_value (head_value),
    .pop        (pop),
    .kept_valid (kept_valid),
    .kept_ready (kept_ready),
    .kept_value (kept_value)
  );

endmodule

// File: hw/rtl/pvf_front.sv
// front part: accepts words and classifies them
module pvf_front
  import pvf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         value_valid,
  output logic                         value_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         push,
  output logic        [VALUE_BITS-1:0] push_value,
  output item_class_t                  push_cls,
  input  logic                         queue_full
);

  localparam int MAG_BITS = VALUE_BITS - 1;

  logic                  hold_valid;
  logic [VALUE_BITS-1:0] hold_value;
  item_class_t           hold_cls;
  item_class_t           cls_next;

  // negative, zero and one never need testing
  always_comb begin
    if (!value[VALUE_BITS-1] && (value[MAG_BITS-1:0] > MAG_BITS'(1))) begin
      cls_next = CLASS_TRIAL;
    end else begin
      cls_next = CLASS_PASS;
    end
  end

  assign push        = hold_valid && !queue_full;
  assign value_ready = !hold_valid || push;
  assign push_value  = hold_value;
  assign push_cls    = hold_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (value_ready) begin
      hold_valid <= value_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (value_ready && value_valid) begin
      hold_value <= value;
      hold_cls   <= cls_next;
    end
  end

endmodule

// File: hw/rtl/pvf_queue.sv
// short queue between front and back parts
`include "prime_value_filter_macros.svh"
module pvf_queue
  import pvf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] push_value,
  input  item_class_t           push_cls,
  output logic                  full,
  input  logic                  pop,
  output queue_tag_t            head_tag,
  output logic [VALUE_BITS-1:0] head_value
);

  localparam int DEPTH      = 2;
  localparam int PTR_BITS   = $clog2(DEPTH);
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] slot_value [DEPTH];
  item_class_t           slot_cls   [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;

  assign full           = (count == COUNT_BITS'(DEPTH));
  assign head_tag.valid = (count != '0);
  assign head_tag.cls   = slot_cls[rd_ptr];
  assign head_value     = slot_value[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_value[wr_ptr] <= push_value;
      slot_cls[wr_ptr]   <= push_cls;
    end
  end

  `PVF_ASSERT_NEVER(a_count_in_range, clk, rst, count > COUNT_BITS'(DEPTH))
  `PVF_ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, count == $past(count) + COUNT_BITS'(1))
  `PVF_ASSERT_NEVER(a_no_push_full, clk, rst, push && full)
  `PVF_ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && (count == '0))

endmodule

// File: hw/rtl/pvf_back.sv
// back part: trial division engine and output register
`include "prime_value_filter_macros.svh"
module pvf_back
  import pvf_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  queue_tag_t                   head_tag,
  input  logic        [VALUE_BITS-1:0] head_value,
  output logic                         pop,
  output logic                         kept_valid,
  input  logic                         kept_ready,
  output logic signed [VALUE_BITS-1:0] kept_value
);

  localparam int MAG_BITS = VALUE_BITS - 1;
  localparam int W        = MAG_BITS + 2;
  localparam int CNT_BITS = $clog2(MAG_BITS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_TEST  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [VALUE_BITS-1:0] word;
  logic [W-1:0]          n;
  logic [W-1:0]          d;
  logic [W-1:0]          sq;
  logic [W-1:0]          rem;
  logic [W-1:0]          shifted;
  logic [MAG_BITS-1:0]   shreg;
  logic [CNT_BITS-1:0]   cnt;
  logic                  out_free;
  logic                  load_out;

  assign n        = W'(word[MAG_BITS-1:0]);
  assign out_free = !kept_valid || kept_ready;
  assign pop      = (state == S_IDLE) && head_tag.valid && out_free;
  assign shifted  = {rem[W-2:0], shreg[MAG_BITS-1]};

  // result register takes a passing word at once or a composite at the end
  assign load_out = (pop && (head_tag.cls == CLASS_PASS)) ||
                    ((state == S_TEST) && (rem == '0));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop && (head_tag.cls == CLASS_TRIAL)) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sq > n) begin
          state_next = S_IDLE;  // no divisor found: prime, dropped
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (rem == '0) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CHECK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kept_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        kept_valid <= 1'b1;
      end else if (kept_ready) begin
        kept_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      word <= head_value;
      d    <= W'(2);
      sq   <= W'(4);
    end
    if (load_out) begin
      kept_value <= (state == S_IDLE) ? head_value : word;
    end
    case (state)
      S_CHECK: begin
        rem   <= '0;
        shreg <= word[MAG_BITS-1:0];
        cnt   <= '0;
      end
      S_DIV: begin
        // one restoring remainder step per cycle
        if (shifted >= d) begin
          rem <= shifted - d;
        end else begin
          rem <= shifted;
        end
        shreg <= shreg << 1;
        cnt   <= cnt + CNT_BITS'(1);
      end
      S_TEST: begin
        d  <= d + W'(1);
        sq <= sq + {d[W-2:0], 1'b1};
      end
      default: begin
      end
    endcase
  end

  `PVF_ASSERT_IMPLY(a_rem_below_divisor, clk, rst, state == S_TEST, rem < d)
  `PVF_ASSERT_IMPLY(a_divisor_from_two, clk, rst, state != S_IDLE, d >= W'(2))
  `PVF_ASSERT_IMPLY(a_pop_only_idle, clk, rst, pop, state == S_IDLE && out_free)

endmodule
